// ===== sv/lfe_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lfe_pkg
// Shared types and constants for the trained LMS FIR equalizer.
// ============================================================================
package lfe_pkg;

    localparam int TAP_COUNT_DEF = 64;
    localparam int PRE_TAPS_DEF  = 42;

    localparam int SAMPLE_W = 16;
    localparam int TAP_W    = 32;
    localparam int STEP_W   = 24;
    localparam int LEAK_W   = 16;
    localparam int BAIL_W   = 16;
    localparam int KEEP_W   = 21;
    localparam int SE_W     = 41;
    localparam int ACC_W    = 64;

    localparam logic [STEP_W-1:0] STEP_RST = 24'd214748;
    localparam logic [LEAK_W-1:0] LEAK_RST = 16'd524;
    localparam logic [BAIL_W-1:0] BAIL_RST = 16'd12800;

    // Tap value 1.0 in Q8.24
    localparam logic [TAP_W-1:0] TAP_ONE = 32'h0100_0000;

    // Command codes
    localparam logic [1:0] CMD_SHIFT  = 2'd0;
    localparam logic [1:0] CMD_FILTER = 2'd1;
    localparam logic [1:0] CMD_TRAIN  = 2'd2;
    localparam logic [1:0] CMD_CLOSE  = 2'd3;

    // Register indexes
    localparam logic [1:0] REG_STEP_SIZE = 2'd0;
    localparam logic [1:0] REG_LEAK      = 2'd1;
    localparam logic [1:0] REG_BAIL      = 2'd2;

    typedef enum logic [1:0] {
        MODE_FILTER,
        MODE_TRAIN,
        MODE_CLOSE
    } mode_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SHIFT,
        ST_SCAN,
        ST_DRAIN,
        ST_YCALC,
        ST_ESTEP,
        ST_CHECK,
        ST_DELTA,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic  issue;
        mode_t mode;
        logic  start;
        logic  sat_clear;
    } pipe_ctrl_t;

endpackage

// ===== sv/lfe_ram.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lfe_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module lfe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/lfe_tap_pipe.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lfe_tap_pipe
// Per-tap arithmetic pipeline: multiply, accumulate, tap update, energy.
// ============================================================================
module lfe_tap_pipe #(
    parameter int TAP_COUNT = lfe_pkg::TAP_COUNT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lfe_pkg::pipe_ctrl_t                 ctrl,
    input  logic [$clog2(TAP_COUNT)-1:0]        issue_k,
    input  logic [lfe_pkg::TAP_W-1:0]           tap_q,
    input  logic [lfe_pkg::SAMPLE_W-1:0]        dl_q,
    input  logic signed [lfe_pkg::SE_W-1:0]     se,
    input  logic [lfe_pkg::KEEP_W-1:0]          keep,
    output logic                                tap_we,
    output logic [$clog2(TAP_COUNT)-1:0]        tap_waddr,
    output logic [lfe_pkg::TAP_W-1:0]           tap_wdata,
    output logic signed [lfe_pkg::ACC_W-1:0]    acc,
    output logic [lfe_pkg::ACC_W-1:0]           energy,
    output logic                                sat_seen,
    output logic                                busy
);

    localparam int AW = $clog2(TAP_COUNT);

    logic                             v_rd_reg, v_pr_reg, v_t_reg, v_sq_reg;
    logic [AW-1:0]                    k_rd_reg, k_pr_reg;
    logic signed [lfe_pkg::TAP_W-1:0] tap_pr_reg;
    logic signed [63:0]               prod_reg, prod_next;
    logic signed [lfe_pkg::TAP_W-1:0] t_reg;
    logic [63:0]                      sq_reg;
    logic signed [63:0]               acc_reg, acc_next;
    logic [63:0]                      energy_reg, energy_next;
    logic                             sat_reg, sat_next;

    logic signed [lfe_pkg::SE_W-1:0]  mul_a;
    logic signed [21:0]               mul_b;
    logic signed [62:0]               mul_p;
    logic signed [63:0]               d_rnd, t_rnd;
    logic signed [33:0]               upd;
    logic                             upd_ovf;
    logic [lfe_pkg::TAP_W-1:0]        upd_sat;
    logic [lfe_pkg::TAP_W-1:0]        t_mag;
    logic [64:0]                      e_sum;

    // Select multiplier operands by mode
    always_comb
    begin
        case (ctrl.mode)
            lfe_pkg::MODE_TRAIN:
            begin
                mul_a = se;
                mul_b = 22'($signed(dl_q));
            end
            lfe_pkg::MODE_CLOSE:
            begin
                mul_a = lfe_pkg::SE_W'($signed(tap_q));
                mul_b = $signed({1'b0, keep});
            end
            default:
            begin
                mul_a = lfe_pkg::SE_W'($signed(tap_q));
                mul_b = 22'($signed(dl_q));
            end
        endcase
        mul_p     = mul_a * mul_b;
        prod_next = {mul_p[62], mul_p};
    end

    // Tap update for training: round, subtract, saturate
    always_comb
    begin
        d_rnd   = (prod_reg + (64'sd1 <<< 29)) >>> 30;
        upd     = 34'(tap_pr_reg) - d_rnd[33:0];
        upd_ovf = (upd[33:31] != 3'b000) && (upd[33:31] != 3'b111);
        if (!upd_ovf)
        begin
            upd_sat = upd[31:0];
        end
        else if (upd[33])
        begin
            upd_sat = 32'h8000_0000;
        end
        else
        begin
            upd_sat = 32'h7FFF_FFFF;
        end
        t_rnd = (prod_reg + (64'sd1 <<< 19)) >>> 20;
    end

    // Write back the updated tap
    always_comb
    begin
        tap_we    = v_pr_reg && (ctrl.mode != lfe_pkg::MODE_FILTER);
        tap_waddr = k_pr_reg;
        tap_wdata = (ctrl.mode == lfe_pkg::MODE_CLOSE) ? t_rnd[31:0] : upd_sat;
    end

    // Accumulate, track saturation, sum energy with saturation
    always_comb
    begin
        t_mag       = t_reg[31] ? 32'(-t_reg) : 32'(t_reg);
        e_sum       = {1'b0, energy_reg} + {1'b0, sq_reg};
        acc_next    = acc_reg;
        energy_next = energy_reg;
        sat_next    = sat_reg;
        if (ctrl.start)
        begin
            acc_next    = '0;
            energy_next = '0;
        end
        else
        begin
            if (v_pr_reg && (ctrl.mode == lfe_pkg::MODE_FILTER))
            begin
                acc_next = acc_reg + prod_reg;
            end
            if (v_sq_reg)
            begin
                energy_next = e_sum[64] ? '1 : e_sum[63:0];
            end
        end
        if (ctrl.sat_clear)
        begin
            sat_next = 1'b0;
        end
        else if (v_pr_reg && (ctrl.mode == lfe_pkg::MODE_TRAIN) && upd_ovf)
        begin
            sat_next = 1'b1;
        end
    end

    // Advance stage valids and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_rd_reg   <= 1'b0;
            v_pr_reg   <= 1'b0;
            v_t_reg    <= 1'b0;
            v_sq_reg   <= 1'b0;
            sat_reg    <= 1'b0;
            acc_reg    <= '0;
            energy_reg <= '0;
        end
        else
        begin
            v_rd_reg   <= ctrl.issue;
            v_pr_reg   <= v_rd_reg;
            v_t_reg    <= v_pr_reg && (ctrl.mode == lfe_pkg::MODE_CLOSE);
            v_sq_reg   <= v_t_reg;
            sat_reg    <= sat_next;
            acc_reg    <= acc_next;
            energy_reg <= energy_next;
        end
    end

    // Hold stage payloads
    always_ff @(posedge clk)
    begin
        k_rd_reg   <= issue_k;
        k_pr_reg   <= k_rd_reg;
        tap_pr_reg <= $signed(tap_q);
        prod_reg   <= prod_next;
        t_reg      <= t_rnd[31:0];
        sq_reg     <= 64'(t_mag) * 64'(t_mag);
    end

    assign acc      = acc_reg;
    assign energy   = energy_reg;
    assign sat_seen = sat_reg;
    assign busy     = v_rd_reg | v_pr_reg | v_t_reg | v_sq_reg;

endmodule

// ===== sv/trained_lms_fir_equalizer.sv =====
`timescale 1ns / 1ps
// ============================================================================
// trained_lms_fir_equalizer
// LMS-trained FIR equalizer with delay line and taps held in RAMs.
// ============================================================================
// A filter yields a sample; a close yields a status after the taps are reloaded
// with the delta if they diverged; no result otherwise. One request at a time:
// shift writes a sample; filter adds a tap pass; train a second pass that updates
// the taps; close a pass that scales them. Each tap pass reads one tap and one
// sample per cycle. Reset: a clearing pass zeroes the delay line and loads the
// delta taps; no request is taken until it ends (config writes still are).
module trained_lms_fir_equalizer #(
    parameter int TAP_COUNT = lfe_pkg::TAP_COUNT_DEF,
    parameter int PRE_TAPS  = lfe_pkg::PRE_TAPS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           command,
    input  logic signed [lfe_pkg::SAMPLE_W-1:0]  sample,
    input  logic signed [lfe_pkg::SAMPLE_W-1:0]  training_symbol,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [lfe_pkg::SAMPLE_W-1:0]  equalized,
    output logic                                 is_status,
    output logic                                 taps_were_reset,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [1:0]                           cfg_index,
    input  logic [lfe_pkg::STEP_W-1:0]           cfg_data
);

    localparam int AW        = $clog2(TAP_COUNT);
    localparam int DELTA_POS = (PRE_TAPS < TAP_COUNT) ? PRE_TAPS : TAP_COUNT - 1;
    localparam logic [AW:0] K_LAST = (AW + 1)'(TAP_COUNT - 1);
    localparam logic [AW:0] K_NUM  = (AW + 1)'(TAP_COUNT);
    localparam logic [AW-1:0] D_POS = AW'(DELTA_POS);

    lfe_pkg::state_t state_reg, state_next;
    lfe_pkg::mode_t  mode_reg, mode_next;
    lfe_pkg::pipe_ctrl_t ctrl;

    logic [AW:0]     k_reg, k_next;
    logic [AW-1:0]   wptr_reg, wptr_next;
    logic [1:0]      cmd_reg;
    logic signed [lfe_pkg::SAMPLE_W-1:0] sample_reg, sym_reg;
    logic signed [lfe_pkg::SAMPLE_W-1:0] y_reg, y_next;
    logic signed [lfe_pkg::SE_W-1:0]     se_reg;
    logic [63:0]                         limit_reg;
    logic                                diverged_reg, diverged;

    logic [lfe_pkg::STEP_W-1:0] step_size_reg;
    logic [lfe_pkg::LEAK_W-1:0] leak_reg;
    logic [lfe_pkg::BAIL_W-1:0] bail_reg;
    logic [lfe_pkg::KEEP_W-1:0] keep;

    logic                                out_valid_reg, out_load;
    logic signed [lfe_pkg::SAMPLE_W-1:0] equalized_reg;
    logic                                is_status_reg, taps_reset_reg;

    logic                          dl_we, tap_we, pipe_we;
    logic [AW-1:0]                 dl_waddr, dl_raddr, tap_waddr, pipe_waddr;
    logic [lfe_pkg::SAMPLE_W-1:0]  dl_wdata, dl_q;
    logic [lfe_pkg::TAP_W-1:0]     tap_wdata, pipe_wdata, tap_q;
    logic [AW:0]                   dl_sum;
    logic signed [63:0]            acc, y_rnd;
    logic [63:0]                   energy;
    logic                          sat_seen, busy;
    logic signed [16:0]            err;
    logic signed [lfe_pkg::SE_W-1:0] se_prod;

    // Configuration registers; always ready
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg <= lfe_pkg::STEP_RST;
            leak_reg      <= lfe_pkg::LEAK_RST;
            bail_reg      <= lfe_pkg::BAIL_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lfe_pkg::REG_STEP_SIZE: step_size_reg <= cfg_data;
                lfe_pkg::REG_LEAK:      leak_reg      <= cfg_data[lfe_pkg::LEAK_W-1:0];
                lfe_pkg::REG_BAIL:      bail_reg      <= cfg_data[lfe_pkg::BAIL_W-1:0];
                default: ;
            endcase
        end
    end

    assign keep = (lfe_pkg::KEEP_W)'(21'h10_0000 - {5'b0, leak_reg});

    // Window position k maps into the circular buffer counting from the oldest entry
    always_comb
    begin
        dl_sum = {1'b0, wptr_reg} + {1'b0, k_reg[AW-1:0]};
        if (dl_sum >= K_NUM)
        begin
            dl_sum = dl_sum - K_NUM;
        end
        dl_raddr = dl_sum[AW-1:0];
    end

    // Filter output rounding and saturation; error times step
    always_comb
    begin
        y_rnd = (acc + (64'sd1 <<< 23)) >>> 24;
        if (y_rnd > 64'sd32767)
        begin
            y_next = 16'sh7FFF;
        end
        else if (y_rnd < -64'sd32768)
        begin
            y_next = -16'sh8000;
        end
        else
        begin
            y_next = y_rnd[15:0];
        end
        err      = 17'(y_reg) - 17'(sym_reg);
        se_prod  = $signed({1'b0, step_size_reg}) * err;
        diverged = sat_seen || (energy > limit_reg);
    end

    // Sequencer: next state and outputs
    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        k_next     = k_reg;
        wptr_next  = wptr_reg;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        dl_we      = 1'b0;
        dl_waddr   = k_reg[AW-1:0];
        dl_wdata   = '0;
        tap_we     = pipe_we;
        tap_waddr  = pipe_waddr;
        tap_wdata  = pipe_wdata;
        ctrl.issue     = 1'b0;
        ctrl.mode      = mode_reg;
        ctrl.start     = 1'b0;
        ctrl.sat_clear = 1'b0;
        case (state_reg)
            lfe_pkg::ST_CLEAR:
            begin
                dl_we     = 1'b1;
                tap_we    = 1'b1;
                tap_waddr = k_reg[AW-1:0];
                tap_wdata = (k_reg[AW-1:0] == D_POS) ? lfe_pkg::TAP_ONE : '0;
                k_next    = k_reg + 1'b1;
                if (k_reg == K_LAST)
                begin
                    k_next     = '0;
                    state_next = lfe_pkg::ST_IDLE;
                end
            end
            lfe_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (command == lfe_pkg::CMD_CLOSE)
                    begin
                        mode_next  = lfe_pkg::MODE_CLOSE;
                        ctrl.start = 1'b1;
                        k_next     = '0;
                        state_next = lfe_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = lfe_pkg::ST_SHIFT;
                    end
                end
            end
            lfe_pkg::ST_SHIFT:
            begin
                dl_we     = 1'b1;
                dl_waddr  = wptr_reg;
                dl_wdata  = sample_reg;
                wptr_next = (wptr_reg == AW'(TAP_COUNT - 1)) ? '0 : wptr_reg + 1'b1;
                if (cmd_reg == lfe_pkg::CMD_SHIFT)
                begin
                    state_next = lfe_pkg::ST_IDLE;
                end
                else
                begin
                    mode_next  = lfe_pkg::MODE_FILTER;
                    ctrl.start = 1'b1;
                    k_next     = '0;
                    state_next = lfe_pkg::ST_SCAN;
                end
            end
            lfe_pkg::ST_SCAN:
            begin
                ctrl.issue = 1'b1;
                k_next     = k_reg + 1'b1;
                if (k_reg == K_LAST)
                begin
                    k_next     = '0;
                    state_next = lfe_pkg::ST_DRAIN;
                end
            end
            lfe_pkg::ST_DRAIN:
            begin
                if (!busy)
                begin
                    case (mode_reg)
                        lfe_pkg::MODE_FILTER: state_next = lfe_pkg::ST_YCALC;
                        lfe_pkg::MODE_CLOSE:  state_next = lfe_pkg::ST_CHECK;
                        default:              state_next = lfe_pkg::ST_IDLE;
                    endcase
                end
            end
            lfe_pkg::ST_YCALC:
            begin
                state_next = (cmd_reg == lfe_pkg::CMD_TRAIN) ? lfe_pkg::ST_ESTEP
                                                             : lfe_pkg::ST_FINISH;
            end
            lfe_pkg::ST_ESTEP:
            begin
                mode_next  = lfe_pkg::MODE_TRAIN;
                k_next     = '0;
                state_next = lfe_pkg::ST_SCAN;
            end
            lfe_pkg::ST_CHECK:
            begin
                ctrl.sat_clear = 1'b1;
                k_next         = '0;
                state_next     = diverged ? lfe_pkg::ST_DELTA : lfe_pkg::ST_FINISH;
            end
            lfe_pkg::ST_DELTA:
            begin
                tap_we    = 1'b1;
                tap_waddr = k_reg[AW-1:0];
                tap_wdata = (k_reg[AW-1:0] == D_POS) ? lfe_pkg::TAP_ONE : '0;
                k_next    = k_reg + 1'b1;
                if (k_reg == K_LAST)
                begin
                    k_next     = '0;
                    state_next = lfe_pkg::ST_FINISH;
                end
            end
            lfe_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = lfe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lfe_pkg::ST_IDLE;
            end
        endcase
    end

    // State, counters and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lfe_pkg::ST_CLEAR;
            mode_reg      <= lfe_pkg::MODE_FILTER;
            k_reg         <= '0;
            wptr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            k_reg     <= k_next;
            wptr_reg  <= wptr_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold request and working payloads
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg    <= command;
            sample_reg <= sample;
            sym_reg    <= training_symbol;
        end
        if (state_reg == lfe_pkg::ST_YCALC)
        begin
            y_reg <= y_next;
        end
        if (state_reg == lfe_pkg::ST_ESTEP)
        begin
            se_reg <= se_prod;
        end
        if (state_reg == lfe_pkg::ST_CHECK)
        begin
            diverged_reg <= diverged;
        end
        limit_reg <= {32'(bail_reg) * 32'(bail_reg), 32'b0};
        if (out_load)
        begin
            is_status_reg  <= (cmd_reg == lfe_pkg::CMD_CLOSE);
            equalized_reg  <= (cmd_reg == lfe_pkg::CMD_CLOSE) ? '0 : y_reg;
            taps_reset_reg <= (cmd_reg == lfe_pkg::CMD_CLOSE) && diverged_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign equalized       = equalized_reg;
    assign is_status       = is_status_reg;
    assign taps_were_reset = taps_reset_reg;

    lfe_ram #(
        .WIDTH (lfe_pkg::SAMPLE_W),
        .DEPTH (TAP_COUNT)
    ) u_dl_ram (
        .clk   (clk),
        .we    (dl_we),
        .waddr (dl_waddr),
        .wdata (dl_wdata),
        .raddr (dl_raddr),
        .rdata (dl_q)
    );

    lfe_ram #(
        .WIDTH (lfe_pkg::TAP_W),
        .DEPTH (TAP_COUNT)
    ) u_tap_ram (
        .clk   (clk),
        .we    (tap_we),
        .waddr (tap_waddr),
        .wdata (tap_wdata),
        .raddr (k_reg[AW-1:0]),
        .rdata (tap_q)
    );

    lfe_tap_pipe #(
        .TAP_COUNT (TAP_COUNT)
    ) u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .issue_k   (k_reg[AW-1:0]),
        .tap_q     (tap_q),
        .dl_q      (dl_q),
        .se        (se_reg),
        .keep      (keep),
        .tap_we    (pipe_we),
        .tap_waddr (pipe_waddr),
        .tap_wdata (pipe_wdata),
        .acc       (acc),
        .energy    (energy),
        .sat_seen  (sat_seen),
        .busy      (busy)
    );

    // Pipeline writes taps only during a tap pass
    assert property (@(posedge clk) disable iff (!rst_n)
        pipe_we |-> (state_reg == lfe_pkg::ST_SCAN || state_reg == lfe_pkg::ST_DRAIN))
        else $error("tap write outside a tap pass");

    // No request is taken while the pipeline still holds work
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !busy)
        else $error("request taken with pipeline busy");

    // A divergent close falls back to the delta taps
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lfe_pkg::ST_CHECK && diverged) |=> state_reg == lfe_pkg::ST_DELTA)
        else $error("divergence did not reload taps");

    // Status results carry a zero sample
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && is_status_reg) |-> equalized_reg == '0)
        else $error("status result with nonzero sample");

endmodule
